// ===== rtl/core/keypad_scan_debounce_autorepeat_core_defines.svh =====
// Assertion macros shared by the keypad scanner RTL.
`ifndef KEYPAD_SCAN_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_AUTOREPEAT_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define KSDA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, off while reset is high.
`define KSDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/ksda_pkg.sv =====
`default_nettype none
package ksda_pkg;

   localparam int ROWS          = 4;
   localparam int COLUMNS       = 3;
   localparam int KEY_COUNT     = 12;
   localparam int COUNTER_WIDTH = 16;
   localparam int COL_W         = 2;
   localparam int CODE_W        = 8;
   localparam int TICK_W        = 16;
   localparam int CSR_ADDR_W    = 4;
   localparam int CSR_DATA_W    = 32;

   typedef logic [COUNTER_WIDTH-1:0]          cnt_type;
   typedef logic [ROWS-1:0][COUNTER_WIDTH-1:0] cnt_row_type;
   typedef logic [COL_W-1:0]                  col_type;
   typedef logic [CODE_W-1:0]                 code_type;
   typedef logic [TICK_W-1:0]                 tick_type;
   typedef logic [ROWS-1:0]                   rows_type;

   // Register indexes on the configuration port
   typedef enum logic [1:0] {
      REG_DEBOUNCE   = 2'd0,
      REG_REPEAT     = 2'd1,
      REG_RUN_CODE   = 2'd2,
      REG_CLEAR_CODE = 2'd3
   } reg_index_type;

   localparam tick_type DEBOUNCE_RESET   = tick_type'(20);
   localparam tick_type REPEAT_RESET     = tick_type'(200);
   localparam code_type RUN_CODE_RESET   = code_type'(10);
   localparam code_type CLEAR_CODE_RESET = code_type'(11);

   // Counter value of a row that was never written since reset
   localparam cnt_type CNT_RESET = cnt_type'(DEBOUNCE_RESET);

   localparam col_type FIRST_COL = col_type'(0);
   localparam col_type MID_COL   = col_type'(1);
   localparam col_type LAST_COL  = col_type'(COLUMNS - 1);

   typedef struct packed {
      tick_type debounce_ticks;
      tick_type repeat_ticks;
      code_type run_key_code;
      code_type clear_key_code;
   } cfg_type;

   typedef struct packed {
      logic     key_valid;
      code_type key_code;
   } key_result_type;

   // Fixed key codes, column by column from bottom row up
   localparam code_type CODE_TABLE [KEY_COUNT] = '{
      code_type'(0), code_type'(7), code_type'(4), code_type'(1),
      code_type'(0), code_type'(8), code_type'(5), code_type'(2),
      code_type'(0), code_type'(9), code_type'(6), code_type'(3)
   };

   // Map a key to its code; the bottom keys of the outer columns are programmable
   function automatic code_type key_code_of(col_type col, logic [1:0] row,
                                            code_type run_key, code_type clear_key);
      logic [3:0] idx;
      code_type   code;
      idx  = {col, row};
      code = '0;
      if (row == 2'd0 && col == FIRST_COL) begin
         code = run_key;
      end else if (row == 2'd0 && col == LAST_COL) begin
         code = clear_key;
      end else if (idx < 4'(KEY_COUNT)) begin
         code = CODE_TABLE[idx];
      end
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ksda_csr.sv =====
`default_nettype none
module ksda_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ksda_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ksda_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [ksda_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready,
   output      ksda_pkg::cfg_type                   cfg
);

   ksda_pkg::cfg_type       cfg_ff, cfg_in;
   ksda_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = ksda_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ksda_pkg::REG_DEBOUNCE:
               cfg_in.debounce_ticks = csr_pwdata[ksda_pkg::TICK_W-1:0];
            ksda_pkg::REG_REPEAT:
               cfg_in.repeat_ticks = csr_pwdata[ksda_pkg::TICK_W-1:0];
            ksda_pkg::REG_RUN_CODE:
               cfg_in.run_key_code = csr_pwdata[ksda_pkg::CODE_W-1:0];
            ksda_pkg::REG_CLEAR_CODE:
               cfg_in.clear_key_code = csr_pwdata[ksda_pkg::CODE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= ksda_pkg::DEBOUNCE_RESET;
         cfg_ff.repeat_ticks   <= ksda_pkg::REPEAT_RESET;
         cfg_ff.run_key_code   <= ksda_pkg::RUN_CODE_RESET;
         cfg_ff.clear_key_code <= ksda_pkg::CLEAR_CODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_idx)
         ksda_pkg::REG_DEBOUNCE:
            csr_prdata = ksda_pkg::CSR_DATA_W'(cfg_ff.debounce_ticks);
         ksda_pkg::REG_REPEAT:
            csr_prdata = ksda_pkg::CSR_DATA_W'(cfg_ff.repeat_ticks);
         ksda_pkg::REG_RUN_CODE:
            csr_prdata = ksda_pkg::CSR_DATA_W'(cfg_ff.run_key_code);
         ksda_pkg::REG_CLEAR_CODE:
            csr_prdata = ksda_pkg::CSR_DATA_W'(cfg_ff.clear_key_code);
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/ksda_row_ram.sv =====
`default_nettype none
module ksda_row_ram (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire ksda_pkg::col_type     rd_addr,
   output      ksda_pkg::cnt_row_type rd_data,
   input  wire logic                  wr_en,
   input  wire ksda_pkg::col_type     wr_addr,
   input  wire ksda_pkg::cnt_row_type wr_data
);

   // One row of countdowns per keypad column
   ksda_pkg::cnt_row_type mem [ksda_pkg::COLUMNS];
   ksda_pkg::cnt_row_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ksda_row_update.sv =====
`default_nettype none
module ksda_row_update (
   input  wire ksda_pkg::col_type        col,
   input  wire ksda_pkg::rows_type       row_levels,
   input  wire ksda_pkg::cnt_row_type    cnt_cur,
   input  wire ksda_pkg::cfg_type        cfg,
   output      ksda_pkg::cnt_row_type    cnt_new,
   output      ksda_pkg::key_result_type result
);

   ksda_pkg::cnt_type debounce_cnt;
   ksda_pkg::cnt_type repeat_cnt;

   assign debounce_cnt = ksda_pkg::cnt_type'(cfg.debounce_ticks);
   assign repeat_cnt   = ksda_pkg::cnt_type'(cfg.repeat_ticks);

   // Count down pressed keys, reload released ones; the highest firing row wins
   always_comb begin
      ksda_pkg::cnt_type dec;
      result = '0;
      cnt_new = cnt_cur;
      for (int r = 0; r < ksda_pkg::ROWS; r++) begin
         dec = cnt_cur[r] - 1'b1;
         if (!row_levels[r]) begin
            if (dec == '0) begin
               result.key_valid = 1'b1;
               result.key_code  = ksda_pkg::key_code_of(col, 2'(r),
                                     cfg.run_key_code, cfg.clear_key_code);
               cnt_new[r] = repeat_cnt;
            end else begin
               cnt_new[r] = dec;
            end
         end else begin
            cnt_new[r] = debounce_cnt;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/keypad_scan_debounce_autorepeat_core.sv =====
`default_nettype none
`include "keypad_scan_debounce_autorepeat_core_defines.svh"
// Keypad scanner for a 3-column by 4-row matrix. Each req item carries the four
// active-low row levels of the column now driven; columns go 0, 1, 2, 0, ...
// Every item yields exactly one rsp item naming the scanned column and, when a
// key's countdown ran out, its code (a held key repeats every repeat_ticks
// scans after the first report at debounce_ticks). One item is taken per clock
// cycle while the rsp side does not stall; a result goes through the registered
// read of the column's countdown row from the row memory and then through the
// update and output register. Neighboring items always touch different rows,
// so a read never meets a pending write to its own row. Per-row valid bits
// make the countdowns read as 20 after reset; there is no clearing pass.
module keypad_scan_debounce_autorepeat_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: [3:0] row_levels, [7:4] zero
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [7:0]                          req_tdata,
   // rsp_tdata: [7:0] key_code, [9:8] scanned_column, [15:10] zero
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [15:0]                         rsp_tdata,
   // rsp_tuser: [0] key_valid
   output      logic                                rsp_tuser,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [ksda_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [ksda_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [ksda_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready
);

   ksda_pkg::cfg_type        cfg;
   ksda_pkg::col_type        col_ff, col_in, col_eff;
   logic                     accept;
   logic                     s1_adv;
   logic                     s1_valid_ff, s1_valid_in;
   ksda_pkg::rows_type       s1_rows_ff;
   ksda_pkg::col_type        s1_col_ff;
   logic                     s1_init_ff;
   logic [ksda_pkg::COLUMNS-1:0] row_written_ff, row_written_in;
   ksda_pkg::cnt_row_type    ram_rd_data;
   ksda_pkg::cnt_row_type    cnt_cur;
   ksda_pkg::cnt_row_type    cnt_new;
   ksda_pkg::key_result_type result;
   logic                     out_valid_ff, out_valid_in;
   ksda_pkg::key_result_type out_result_ff;
   ksda_pkg::col_type        out_col_ff;

   ksda_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake and stage advance
   assign s1_adv     = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_adv;
   assign accept     = req_tvalid & req_tready;

   // Column rotation; an unused code counts as the first column
   assign col_eff = (col_ff == 2'd3) ? ksda_pkg::FIRST_COL : col_ff;
   always_comb begin
      col_in = col_ff;
      if (accept) begin
         col_in = (col_eff == ksda_pkg::LAST_COL) ? ksda_pkg::FIRST_COL
                                                   : col_eff + ksda_pkg::MID_COL;
      end
   end

   ksda_row_ram u_row_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (ram_rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (cnt_new)
   );

   // Unwritten rows read as the reset countdown
   assign cnt_cur = s1_init_ff ? ram_rd_data : {ksda_pkg::ROWS{ksda_pkg::CNT_RESET}};

   ksda_row_update u_row_update (
      .col        (s1_col_ff),
      .row_levels (s1_rows_ff),
      .cnt_cur    (cnt_cur),
      .cfg        (cfg),
      .cnt_new    (cnt_new),
      .result     (result)
   );

   // Mark rows written back
   always_comb begin
      row_written_in = row_written_ff;
      if (s1_adv) begin
         row_written_in[s1_col_ff] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= ksda_pkg::FIRST_COL;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         row_written_ff <= '0;
      end else begin
         col_ff         <= col_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
         row_written_ff <= row_written_in;
      end
   end

   // Capture the item alongside its memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rows_ff <= req_tdata[ksda_pkg::ROWS-1:0];
         s1_col_ff  <= col_eff;
         s1_init_ff <= row_written_ff[col_eff];
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_result_ff <= result;
         out_col_ff    <= s1_col_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.key_valid;
   assign rsp_tdata  = {6'd0, out_col_ff, out_result_ff.key_code};

   `KSDA_ASSERT_IMPLY(a_no_row_collision, clock, reset, accept && s1_adv, col_eff != s1_col_ff)
   `KSDA_ASSERT_IMPLY(a_code_zero_when_idle, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[7:0] == 8'd0)
   `KSDA_ASSERT_IMPLY(a_column_in_range, clock, reset, rsp_tvalid, rsp_tdata[9:8] != 2'd3)
   `KSDA_ASSERT_NEXT(a_column_rotates, clock, reset, accept, col_ff == (($past(col_eff) == ksda_pkg::LAST_COL) ? ksda_pkg::FIRST_COL : $past(col_eff) + ksda_pkg::MID_COL))

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ksda_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 300;

   // Fixed key codes, column by column from the bottom row up
   localparam logic [7:0] FIXED_CODES [KEY_COUNT] = '{
      8'd0, 8'd7, 8'd4, 8'd1,
      8'd0, 8'd8, 8'd5, 8'd2,
      8'd0, 8'd9, 8'd6, 8'd3
   };

   typedef struct {
      logic       valid;
      logic [7:0] code;
      logic [1:0] col;
   } key_report_type;

   typedef struct {
      logic [3:0] rows;
      logic       hold_for_drain;
   } scan_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire logic   req_tready;
   logic [7:0]  req_tdata = 8'h0F;
   wire logic   rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire logic [15:0] rsp_tdata;
   wire logic   rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   wire logic [CSR_DATA_W-1:0] csr_prdata;
   wire logic   csr_pready;

   // Mirror of the block's registers and scan state
   logic [15:0] cfg_debounce   = 16'd20;
   logic [15:0] cfg_repeat     = 16'd200;
   logic [7:0]  cfg_run_key    = 8'd10;
   logic [7:0]  cfg_clear_key  = 8'd11;
   logic [1:0]  scan_col = 2'd0;
   logic [15:0] countdown [KEY_COUNT];

   key_report_type reports_due [$];
   scan_item_type  scans_waiting [$];
   int          items_queued = 0;
   int          items_taken = 0;
   int          errors = 0;
   logic        req_took = 1'b0;
   logic        calm = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   int          long_hold_ask = 0;
   int          long_hold_seen = 0;
   int          idle_cycles = 0;
   logic [1:0]  gen_col = 2'd0;
   logic [3:0]  held [COLUMNS];

   keypad_scan_debounce_autorepeat_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      // [3:0] row_levels, [7:4] zero
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      // [7:0] key_code, [9:8] scanned_column, [15:10] zero
      .rsp_tdata   (rsp_tdata),
      // [0] key_valid
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   function automatic logic [7:0] code_for(input logic [1:0] col, input int row);
      logic [7:0] code;
      code = FIXED_CODES[col * ROWS + row];
      if (row == 0 && col == FIRST_COL) code = cfg_run_key;
      if (row == 0 && col == LAST_COL) code = cfg_clear_key;
      return code;
   endfunction

   // Advance the countdowns of the driven column and work out its report
   function automatic key_report_type scan_column(input logic [3:0] rows);
      key_report_type rep;
      logic [1:0]  col;
      logic [15:0] left;
      int          key;
      col = (scan_col < COLUMNS) ? scan_col : FIRST_COL;
      rep.valid = 1'b0;
      rep.code  = 8'd0;
      rep.col   = col;
      for (int r = 0; r < ROWS; r++) begin
         key = col * ROWS + r;
         if (!rows[r]) begin
            left = countdown[key] - 16'd1;
            if (left == 16'd0) begin
               // higher rows come later, so the highest firing row wins
               rep.valid = 1'b1;
               rep.code  = code_for(col, r);
               left      = cfg_repeat;
            end
            countdown[key] = left;
         end else begin
            countdown[key] = cfg_debounce;
         end
      end
      scan_col = (col == LAST_COL) ? FIRST_COL : col + 2'd1;
      return rep;
   endfunction

   function automatic logic [31:0] reg_value(input reg_index_type idx);
      case (idx)
         REG_DEBOUNCE: return 32'(cfg_debounce);
         REG_REPEAT:   return 32'(cfg_repeat);
         REG_RUN_CODE: return 32'(cfg_run_key);
         default:      return 32'(cfg_clear_key);
      endcase
   endfunction

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      // only the register's own bits are kept
      case (idx)
         REG_DEBOUNCE: cfg_debounce   = value[15:0];
         REG_REPEAT:   cfg_repeat     = value[15:0];
         REG_RUN_CODE: cfg_run_key    = value[7:0];
         default:      cfg_clear_key  = value[7:0];
      endcase
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_check(input reg_index_type idx);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      csr_paddr   = CSR_ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== reg_value(idx)) report_mismatch(idx.name(), csr_prdata, reg_value(idx));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Program all four registers with junk in the unused upper bits, then read back
   task automatic set_timing(input logic [15:0] dbn, input logic [15:0] rep,
                             input logic [7:0] run_key, input logic [7:0] clear_key);
      csr_write(REG_DEBOUNCE, {16'($urandom), dbn});
      csr_write(REG_REPEAT, {16'($urandom), rep});
      csr_write(REG_RUN_CODE, {24'($urandom), run_key});
      csr_write(REG_CLEAR_CODE, {24'($urandom), clear_key});
      csr_check(REG_DEBOUNCE);
      csr_check(REG_REPEAT);
      csr_check(REG_RUN_CODE);
      csr_check(REG_CLEAR_CODE);
   endtask

   task automatic push_scan(input logic [3:0] rows, input logic drain);
      scan_item_type item;
      item.rows = rows;
      item.hold_for_drain = drain;
      scans_waiting.push_back(item);
      items_queued++;
      gen_col = (gen_col == LAST_COL) ? FIRST_COL : gen_col + 2'd1;
   endtask

   function automatic logic [3:0] pick_pattern();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 4'hF;
         4, 5, 6, 7: return ~(4'h1 << $urandom_range(0, 3));
         8:          return ~((4'h1 << $urandom_range(0, 3)) | (4'h1 << $urandom_range(0, 3)));
         default:    return 4'($urandom);
      endcase
   endfunction

   // Held keys per column that change now and then, with contact bounce mixed in
   task automatic queue_scans(input int count, input int drain_at);
      logic [3:0] rows;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) held[gen_col] = pick_pattern();
         rows = held[gen_col];
         if ($urandom_range(0, 19) == 0) rows = 4'($urandom);
         push_scan(rows, i == drain_at);
      end
   endtask

   // Wait until every item is taken and every result checked
   task automatic settle();
      do @(negedge clock); while (items_taken != items_queued || reports_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Offer pending items, with random gaps
   always @(negedge clock) begin : drive_scans
      logic       offer;
      logic [3:0] rows;
      offer = req_tvalid;
      rows  = req_tdata[3:0];
      if (reset) begin
         offer = 1'b0;
      end else if (!req_tvalid || req_took) begin
         offer = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (scans_waiting.size() > 0) begin
            if (scans_waiting[0].hold_for_drain && reports_due.size() > 0) begin
               offer = 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(1, 13) - 1;
            end else begin
               rows  = scans_waiting[0].rows;
               offer = 1'b1;
               void'(scans_waiting.pop_front());
            end
         end
      end
      req_tvalid <= offer;
      req_tdata  <= {4'h0, rows};
   end

   // Pace the result side: random stalls plus one long hold-off on request
   always @(negedge clock) begin : pace_results
      logic ready;
      ready = 1'b1;
      if (long_hold_ask != long_hold_seen) begin
         long_hold_seen = long_hold_ask;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         ready = 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         ready = 1'b0;
      end
      rsp_tready <= ready;
   end

   // Check results against the oldest expectation, then predict new items
   always @(posedge clock) begin : check_results
      key_report_type want;
      req_took <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (reports_due.size() == 0) begin
               report_mismatch("result with nothing expected", 32'(rsp_tdata), 32'd0);
            end else begin
               want = reports_due.pop_front();
               if (rsp_tuser !== want.valid)
                  report_mismatch("key_valid", 32'(rsp_tuser), 32'(want.valid));
               if (rsp_tdata[7:0] !== want.code)
                  report_mismatch("key_code", 32'(rsp_tdata[7:0]), 32'(want.code));
               if (rsp_tdata[9:8] !== want.col)
                  report_mismatch("scanned_column", 32'(rsp_tdata[9:8]), 32'(want.col));
               if (rsp_tdata[15:10] !== 6'd0)
                  report_mismatch("rsp_tdata padding", 32'(rsp_tdata[15:10]), 32'd0);
            end
         end
         if (req_tvalid && req_tready) begin
            reports_due.push_back(scan_column(req_tdata[3:0]));
            items_taken++;
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      logic [3:0] multi_fire [13];
      logic [3:0] bottom_fire [9];
      logic [3:0] zero_reload [6];
      multi_fire  = '{4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
                      4'hE, 4'hD, 4'hB, 4'h7};
      bottom_fire = '{4'hF, 4'hF, 4'hF, 4'hE, 4'hE, 4'hE, 4'hE, 4'hE, 4'hE};
      zero_reload = '{4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0};
      for (int k = 0; k < KEY_COUNT; k++) countdown[k] = 16'd20;
      for (int c = 0; c < COLUMNS; c++) held[c] = 4'hF;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset values read back
      csr_check(REG_DEBOUNCE);
      csr_check(REG_REPEAT);
      csr_check(REG_RUN_CODE);
      csr_check(REG_CLEAR_CODE);

      // All keys fire together: the top row wins
      set_timing(16'd2, 16'd3, 8'hFF, 8'h00);
      foreach (multi_fire[i]) push_scan(multi_fire[i], 1'b0);
      settle();

      // Bottom keys fire alone, then a zero repeat reload wraps
      set_timing(16'd1, 16'd0, 8'h00, 8'hFF);
      foreach (bottom_fire[i]) push_scan(bottom_fire[i], 1'b0);
      settle();

      // Zero debounce reload wraps on the first press
      set_timing(16'd0, 16'd5, 8'h5A, 8'hA5);
      foreach (zero_reload[i]) push_scan(zero_reload[i], 1'b0);
      settle();

      // Shortest timing: held keys report on every scan
      set_timing(16'd1, 16'd1, 8'($urandom), 8'($urandom));
      queue_scans(110, -1);
      settle();

      // Long result hold-off fills the block; one mid-run drain pause
      set_timing(16'd3, 16'd5, 8'($urandom), 8'($urandom));
      queue_scans(130, 90);
      long_hold_ask++;
      settle();

      // Longest timing: nothing gets reported
      set_timing(16'hFFFF, 16'hFFFF, 8'($urandom), 8'($urandom));
      queue_scans(40, -1);
      settle();

      for (int p = 0; p < 5; p++) begin
         set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                    8'($urandom), 8'($urandom));
         queue_scans(120, -1);
         settle();
      end

      // First report only, then no repeats
      set_timing(16'd2, 16'hFFFF, 8'($urandom), 8'($urandom));
      queue_scans(80, -1);
      settle();

      set_timing(16'hFFFF, 16'd1, 8'($urandom), 8'($urandom));
      queue_scans(40, -1);
      settle();

      // Closing stretch at full rate on both sides
      calm = 1'b1;
      set_timing(16'd4, 16'd2, 8'($urandom), 8'($urandom));
      queue_scans(150, -1);
      settle();
      repeat (8) @(posedge clock);

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== keypad_scan_debounce_autorepeat_core.f =====
+incdir+rtl/core
rtl/core/ksda_pkg.sv
rtl/core/ksda_csr.sv
rtl/core/ksda_row_ram.sv
rtl/core/ksda_row_update.sv
rtl/core/keypad_scan_debounce_autorepeat_core.sv
test/testbench.sv
